// File: rtl/virtual_region_table_allocator_assert.svh
// Assertion macros used by the allocator top level.
`ifndef VIRTUAL_REGION_TABLE_ALLOCATOR_ASSERT_SVH
`define VIRTUAL_REGION_TABLE_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, checked only outside reset.
`define VRTA_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked only outside reset.
`define VRTA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/vrta_pkg.sv
// Shared constants, types and codes of the region table allocator.
package vrta_pkg;
	localparam int TABLE_ENTRIES = 512;
	localparam int PAGE_BYTES    = 4096;
	localparam int PAGE_SH       = $clog2(PAGE_BYTES);
	localparam int IDX_W         = $clog2(TABLE_ENTRIES);
	localparam int ADDR_W        = 32;
	localparam int PAGES_W       = 21;
	localparam int BYTES_W       = PAGES_W + PAGE_SH;
	localparam logic [PAGES_W-1:0] PAGES_MAX = {PAGES_W{1'b1}};

	typedef enum logic [1:0] {
		OP_ALLOC   = 2'd0,
		OP_RELEASE = 2'd1,
		OP_CHECK   = 2'd2,
		OP_NONE    = 2'd3
	} opcode_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_FULL      = 2'd1,
		ST_NOT_FOUND = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_RUN,
		S_HOLD
	} state_t;

	typedef struct packed {
		logic [ADDR_W-1:0]  start;
		logic [PAGES_W-1:0] pages;
	} entry_t;
endpackage

// File: rtl/vrta_cell.sv
// One table entry of the rotating region ring.
module vrta_cell
	import vrta_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   en,
	input  entry_t d,
	output entry_t q
);
	entry_t q_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q_q <= '0;
		end else if (en) begin
			q_q <= d;
		end
	end

	assign q = q_q;
endmodule

// File: rtl/vrta_ctrl.sv
// Sequencer at the head of the ring: runs one full rotation per operation.
module vrta_ctrl
	import vrta_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [1:0]          opcode,
	input  logic [ADDR_W-1:0]   request_bytes,
	input  logic [ADDR_W-1:0]   query_address,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [1:0]          status,
	output logic [ADDR_W-1:0]   result_address,
	output logic [PAGES_W-1:0]  page_count,
	output logic                legitimate,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [ADDR_W-1:0]   pool_base,
	input  entry_t              head,
	input  entry_t              next,
	output entry_t              tail,
	output logic                shift
);
	state_t state_q, state_d;
	logic [IDX_W-1:0]   idx_q;
	opcode_t            op_q;
	logic [ADDR_W-1:0]  addr_q;
	logic [PAGES_W-1:0] req_q;
	logic [ADDR_W-1:0]  base_q;
	logic [ADDR_W-1:0]  prev_end_q;
	logic               found_q, compact_q;
	logic [ADDR_W-1:0]  res_addr_q;
	logic [PAGES_W-1:0] res_pages_q;

	logic               out_valid_q;
	logic [1:0]         status_q;
	logic [ADDR_W-1:0]  result_address_q;
	logic [PAGES_W-1:0] page_count_q;
	logic               legitimate_q;

	logic               accept, last, out_free, load_out;
	logic [ADDR_W:0]    round_sum;
	logic [ADDR_W:0]    pages_raw;
	logic [PAGES_W-1:0] req_pages;
	logic [PAGES_W-1:0] hp;
	logic               occupied;
	logic [BYTES_W-1:0] hbytes;
	logic [ADDR_W-1:0]  offset;
	logic               alloc_hit, rel_hit, chk_hit;
	entry_t             tail_d;

	assign accept   = in_valid && !in_stall;
	assign last     = idx_q == IDX_W'(TABLE_ENTRIES - 1);
	assign out_free = !(out_valid_q && out_stall);
	// The result loads after the rotation, once the last entry's outcome is registered.
	assign load_out = state_q == S_HOLD && out_free;

	// Round up to whole pages, at least one, saturating at the field width.
	assign round_sum = {1'b0, request_bytes} + (ADDR_W+1)'(PAGE_BYTES - 1);
	assign pages_raw = round_sum >> PAGE_SH;
	always_comb begin
		if (pages_raw == '0) begin
			req_pages = PAGES_W'(1);
		end else if (pages_raw > (ADDR_W+1)'(PAGES_MAX)) begin
			req_pages = PAGES_MAX;
		end else begin
			req_pages = pages_raw[PAGES_W-1:0];
		end
	end

	// Entry zero is always one page long.
	assign hp       = (idx_q == '0) ? PAGES_W'(1) : head.pages;
	assign occupied = hp != '0;
	assign hbytes   = {hp, {PAGE_SH{1'b0}}};
	assign offset   = addr_q - head.start;

	assign alloc_hit = op_q == OP_ALLOC && !found_q && idx_q != '0 && !occupied;
	assign rel_hit   = op_q == OP_RELEASE && !found_q && idx_q != '0 && occupied
		&& head.start == addr_q;
	assign chk_hit   = occupied && ({{(BYTES_W-ADDR_W){1'b0}}, offset} < hbytes);

	// Once the released entry is dropped, each slot takes its upper neighbor.
	always_comb begin
		tail_d.start = head.start;
		tail_d.pages = hp;
		if (compact_q || rel_hit) begin
			tail_d = last ? '0 : next;
		end else if (alloc_hit) begin
			tail_d.start = prev_end_q;
			tail_d.pages = req_q;
		end
	end
	assign tail = tail_d;

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) state_d = S_RUN;
			end
			S_RUN: begin
				if (last) state_d = S_HOLD;
			end
			S_HOLD: begin
				if (out_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		in_stall  = 1'b1;
		cfg_ready = 1'b0;
		shift     = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_stall  = 1'b0;
				cfg_ready = 1'b1;
			end
			S_RUN: begin
				shift = 1'b1;
			end
			S_HOLD: begin
				in_stall = 1'b1;
			end
			default: in_stall = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			idx_q       <= '0;
			base_q      <= '0;
			found_q     <= 1'b0;
			compact_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				base_q <= pool_base;
			end
			if (accept) begin
				idx_q     <= '0;
				found_q   <= opcode == OP_CHECK && query_address == base_q;
				compact_q <= 1'b0;
			end else if (shift) begin
				idx_q <= idx_q + IDX_W'(1);
				if (alloc_hit || rel_hit || (op_q == OP_CHECK && chk_hit)) begin
					found_q <= 1'b1;
				end
				if (rel_hit) begin
					compact_q <= 1'b1;
				end
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q   <= opcode_t'(opcode);
			addr_q <= query_address;
			req_q  <= req_pages;
		end
		if (shift) begin
			prev_end_q <= head.start + hbytes[ADDR_W-1:0];
			if (alloc_hit) begin
				res_addr_q  <= prev_end_q;
				res_pages_q <= req_q;
			end else if (rel_hit) begin
				res_addr_q  <= head.start;
				res_pages_q <= head.pages;
			end
		end
		if (load_out) begin
			status_q         <= ST_OK;
			result_address_q <= '0;
			page_count_q     <= '0;
			legitimate_q     <= 1'b0;
			case (op_q)
				OP_ALLOC: begin
					if (found_q) begin
						result_address_q <= res_addr_q;
						page_count_q     <= res_pages_q;
					end else begin
						status_q <= ST_FULL;
					end
				end
				OP_RELEASE: begin
					if (found_q) begin
						result_address_q <= res_addr_q;
						page_count_q     <= res_pages_q;
					end else begin
						status_q <= ST_NOT_FOUND;
					end
				end
				OP_CHECK: begin
					legitimate_q <= found_q;
				end
				default: status_q <= ST_OK;
			endcase
		end
	end

	assign out_valid      = out_valid_q;
	assign status         = status_q;
	assign result_address = result_address_q;
	assign page_count     = page_count_q;
	assign legitimate     = legitimate_q;
endmodule

// File: rtl/virtual_region_table_allocator.sv
// Top level of the virtual region table allocator: ring of entry cells plus sequencer.
//
//   channel  direction  handshake             payload
//   in       to block   in_valid / in_stall   opcode, request_bytes, query_address
//   out      from block out_valid / out_stall status, result_address, page_count, legitimate
//   cfg      to block   cfg_valid / cfg_ready pool_base
//
// Every operation rotates the 512-entry ring once past the single head cell the
// sequencer inspects (S_RUN); the result register then loads in S_HOLD once the
// output is free, and the next item is taken after the return to S_IDLE.
// A new item is taken while the previous result still waits in the output register.
// Reset clears all entries; entry zero starts at pool_base once configured and is one page long.
// If the output is stalled when a result is ready, the block holds until it drains.
module virtual_region_table_allocator
	import vrta_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         opcode,
	input  logic [ADDR_W-1:0]  request_bytes,
	input  logic [ADDR_W-1:0]  query_address,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [1:0]         status,
	output logic [ADDR_W-1:0]  result_address,
	output logic [PAGES_W-1:0] page_count,
	output logic               legitimate,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [ADDR_W-1:0]  pool_base
);
	`include "virtual_region_table_allocator_assert.svh"

	entry_t ring [TABLE_ENTRIES];
	entry_t tail;
	entry_t base_entry;
	logic   shift;

	assign base_entry.start = pool_base;
	assign base_entry.pages = ring[0].pages;

	for (genvar k = 0; k < TABLE_ENTRIES; k++) begin : g_cell
		if (k == 0) begin : g_head
			// The head cell also takes the base address on a configuration transfer.
			vrta_cell u_cell (
				.clk    (clk),
				.arst_n (arst_n),
				.en     (shift || (cfg_valid && cfg_ready)),
				.d      (shift ? ring[1] : base_entry),
				.q      (ring[0])
			);
		end else if (k == TABLE_ENTRIES - 1) begin : g_tail
			vrta_cell u_cell (
				.clk    (clk),
				.arst_n (arst_n),
				.en     (shift),
				.d      (tail),
				.q      (ring[k])
			);
		end else begin : g_mid
			vrta_cell u_cell (
				.clk    (clk),
				.arst_n (arst_n),
				.en     (shift),
				.d      (ring[k+1]),
				.q      (ring[k])
			);
		end
	end

	vrta_ctrl u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.opcode         (opcode),
		.request_bytes  (request_bytes),
		.query_address  (query_address),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.status         (status),
		.result_address (result_address),
		.page_count     (page_count),
		.legitimate     (legitimate),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.pool_base      (pool_base),
		.head           (ring[0]),
		.next           (ring[1]),
		.tail           (tail),
		.shift          (shift)
	);

	`VRTA_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "accept did not start a rotation")
	`VRTA_ASSERT_NOW(a_cfg_only_idle, cfg_ready, !in_stall && !shift, "config ready while busy")
	`VRTA_ASSERT_NOW(a_result_after_work, $rose(out_valid), $past(in_stall), "result without a rotation")
endmodule

// File: tb/tb_top.sv
// Self-checking testbench for the virtual region table allocator.
module tb_top;
	import vrta_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic [1:0]         opcode = OP_NONE;
	logic [ADDR_W-1:0]  request_bytes = '0;
	logic [ADDR_W-1:0]  query_address = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic [1:0]         status;
	logic [ADDR_W-1:0]  result_address;
	logic [PAGES_W-1:0] page_count;
	logic               legitimate;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [ADDR_W-1:0]  pool_base = '0;

	typedef struct packed {
		logic [1:0]         st;
		logic [ADDR_W-1:0]  addr;
		logic [PAGES_W-1:0] pages;
		logic               legit;
	} answer_t;

	// Shadow copy of the region table.
	logic [ADDR_W-1:0]  shadow_start [TABLE_ENTRIES];
	logic [PAGES_W-1:0] shadow_pages [TABLE_ENTRIES];
	logic [ADDR_W-1:0]  shadow_base;

	answer_t pending_answers[$];
	int      mismatches = 0;
	int      answers_seen = 0;
	int      items_sent = 0;
	longint  cycle_count = 0;
	bit      long_hold = 1'b0;
	bit      stall_random = 1'b1;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	virtual_region_table_allocator u_dut (
		.clk, .arst_n, .in_valid, .in_stall, .opcode, .request_bytes, .query_address,
		.out_valid, .out_stall, .status, .result_address, .page_count, .legitimate,
		.cfg_valid, .cfg_ready, .pool_base
	);

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > 64'd4000000) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("** virtual_region_table_allocator: FAILED **");
			$finish;
		end
	end

	task automatic report_mismatch(input string what, input longint got, input longint want);
		mismatches++;
		$display("mismatch at cycle %0d: %s got %0h expected %0h", cycle_count, what, got, want);
	endtask

	task automatic reset_table();
		for (int i = 0; i < TABLE_ENTRIES; i++) begin
			shadow_start[i] = '0;
			shadow_pages[i] = '0;
		end
		shadow_base = '0;
		shadow_pages[0] = PAGES_W'(1);
	endtask

	function automatic logic [PAGES_W-1:0] pages_for(input logic [ADDR_W-1:0] bytes_req);
		logic [ADDR_W:0] p;
		p = ({1'b0, bytes_req} + (ADDR_W+1)'(PAGE_BYTES - 1)) >> PAGE_SH;
		if (p == '0) p = (ADDR_W+1)'(1);
		if (p > (ADDR_W+1)'(PAGES_MAX)) p = (ADDR_W+1)'(PAGES_MAX);
		return p[PAGES_W-1:0];
	endfunction

	// Applies one operation to the shadow table and returns the answer it should give.
	function automatic answer_t predict_region_op(input logic [1:0] op,
			input logic [ADDR_W-1:0] bytes_req, input logic [ADDR_W-1:0] addr);
		answer_t a;
		int      i;
		logic [ADDR_W-1:0] off;
		logic [BYTES_W-1:0] len;
		a = '0;
		case (op)
			OP_ALLOC: begin
				a.st = ST_FULL;
				for (i = 1; i < TABLE_ENTRIES; i++) begin
					if (shadow_pages[i] == 0) begin
						len = {shadow_pages[i-1], {PAGE_SH{1'b0}}};
						shadow_start[i] = shadow_start[i-1] + len[ADDR_W-1:0];
						shadow_pages[i] = pages_for(bytes_req);
						a.st = ST_OK;
						a.addr = shadow_start[i];
						a.pages = shadow_pages[i];
						break;
					end
				end
			end
			OP_RELEASE: begin
				for (i = 1; i < TABLE_ENTRIES; i++)
					if (shadow_pages[i] != 0 && shadow_start[i] == addr) break;
				if (i >= TABLE_ENTRIES) begin
					a.st = ST_NOT_FOUND;
				end else begin
					a.st = ST_OK;
					a.addr = shadow_start[i];
					a.pages = shadow_pages[i];
					for (; i < TABLE_ENTRIES - 1; i++) begin
						shadow_start[i] = shadow_start[i+1];
						shadow_pages[i] = shadow_pages[i+1];
					end
					shadow_start[TABLE_ENTRIES-1] = '0;
					shadow_pages[TABLE_ENTRIES-1] = '0;
				end
			end
			OP_CHECK: begin
				a.legit = (addr == shadow_base);
				for (i = 0; i < TABLE_ENTRIES && !a.legit; i++) begin
					off = addr - shadow_start[i];
					len = {shadow_pages[i], {PAGE_SH{1'b0}}};
					if (shadow_pages[i] != 0 && {1'b0, off} < len) a.legit = 1'b1;
				end
			end
			default: ;
		endcase
		return a;
	endfunction

	function automatic int short_or_long_gap();
		if ($urandom_range(0, 19) == 0) return $urandom_range(10, 60);
		if ($urandom_range(0, 2) == 0) return 0;
		return $urandom_range(0, 3);
	endfunction

	// Sends one item; the expectation is queued at the transfer edge.
	// Valid stays high into a following item that comes without a gap.
	task automatic send_item(input logic [1:0] op, input logic [ADDR_W-1:0] bytes_req,
			input logic [ADDR_W-1:0] addr, input int with_gaps);
		int gap;
		gap = (with_gaps != 0) ? short_or_long_gap() : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		opcode <= op;
		request_bytes <= bytes_req;
		query_address <= addr;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		pending_answers.push_back(predict_region_op(op, bytes_req, addr));
		items_sent++;
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (pending_answers.size() != 0) @(posedge clk);
		repeat (600) @(posedge clk);
	endtask

	task automatic write_base(input logic [ADDR_W-1:0] b);
		cfg_valid <= 1'b1;
		pool_base <= b;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		shadow_base = b;
		shadow_start[0] = b;
	endtask

	// Receiver side: random stalls, or a long hold when requested.
	always @(posedge clk) begin
		if (long_hold) out_stall <= 1'b1;
		else if (stall_random) out_stall <= ($urandom_range(0, 3) == 0);
		else out_stall <= 1'b0;
	end

	always @(posedge clk) begin
		answer_t w;
		if (arst_n && out_valid && !out_stall) begin
			answers_seen++;
			if (pending_answers.size() == 0) begin
				report_mismatch("unexpected transfer", 64'd1, 64'd0);
			end else begin
				w = pending_answers.pop_front();
				if (status !== w.st)
					report_mismatch("status", longint'(status), longint'(w.st));
				if (result_address !== w.addr)
					report_mismatch("result_address", longint'(result_address),
						longint'(w.addr));
				if (page_count !== w.pages)
					report_mismatch("page_count", longint'(page_count), longint'(w.pages));
				if (legitimate !== w.legit)
					report_mismatch("legitimate", longint'(legitimate), longint'(w.legit));
			end
		end
	end

	function automatic logic [ADDR_W-1:0] live_start();
		int n;
		n = 0;
		for (int i = 1; i < TABLE_ENTRIES; i++) if (shadow_pages[i] != 0) n++;
		if (n == 0) return $urandom;
		n = $urandom_range(1, n);
		for (int i = 1; i < TABLE_ENTRIES; i++)
			if (shadow_pages[i] != 0 && --n == 0) return shadow_start[i];
		return '0;
	endfunction

	task automatic test_directed();
		send_item(OP_CHECK, '0, '0, 0);
		send_item(OP_ALLOC, '0, '0, 0);
		send_item(OP_ALLOC, 32'd1, '1, 0);
		send_item(OP_ALLOC, PAGE_BYTES, '0, 0);
		send_item(OP_ALLOC, PAGE_BYTES + 1, '0, 0);
		send_item(OP_ALLOC, '1, '1, 0);
		send_item(OP_CHECK, '0, 32'h0000_0FFF, 0);
		send_item(OP_CHECK, '0, 32'h0000_1000, 0);
		send_item(OP_CHECK, '0, 32'h0000_4FFF, 0);
		send_item(OP_CHECK, '0, 32'h0000_5000, 0);
		send_item(OP_CHECK, '0, '1, 0);
		send_item(OP_RELEASE, '0, 32'h0000_1000, 0);
		send_item(OP_RELEASE, '0, 32'h0000_1000, 0);
		send_item(OP_RELEASE, '0, 32'h1234_5000, 0);
		send_item(OP_RELEASE, '0, '0, 0);
		send_item(OP_NONE, '1, '1, 0);
		send_item(OP_CHECK, '0, 32'h0000_2000, 0);
		drain();
	endtask

	// Near the top of the address space regions wrap past zero.
	task automatic test_wrapping_base();
		write_base(32'hFFFF_E000);
		send_item(OP_ALLOC, 32'h0000_5000, '0, 1);
		send_item(OP_CHECK, '0, 32'hFFFF_F000, 1);
		send_item(OP_CHECK, '0, 32'h0000_3FFF, 1);
		send_item(OP_CHECK, '0, 32'h0000_4000, 1);
		send_item(OP_CHECK, '0, 32'hFFFF_E000, 1);
		drain();
	endtask

	// Filling the table reaches the full case; later items work on a crowded table.
	task automatic test_fill_table();
		for (int i = 0; i < TABLE_ENTRIES; i++)
			send_item(OP_ALLOC, $urandom_range(0, 3 * PAGE_BYTES), '0, 0);
		send_item(OP_ALLOC, 32'd1, '0, 0);
		drain();
	endtask

	task automatic test_random(input int count);
		logic [ADDR_W-1:0] b;
		int k;
		for (int n = 0; n < count; n++) begin
			k = $urandom_range(0, 99);
			if (k < 40) begin
				b = ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 8 * PAGE_BYTES);
				send_item(OP_ALLOC, b, $urandom, 1);
			end else if (k < 65) begin
				send_item(OP_RELEASE, $urandom,
					($urandom_range(0, 4) == 0) ? $urandom : live_start(), 1);
			end else if (k < 95) begin
				b = live_start() + $urandom_range(0, 6 * PAGE_BYTES) - PAGE_BYTES;
				send_item(OP_CHECK, $urandom, ($urandom_range(0, 4) == 0) ? $urandom : b, 1);
			end else begin
				send_item(OP_NONE, $urandom, $urandom, 1);
			end
		end
	endtask

	// The receiver holds off while items keep coming, so the block backs up.
	task automatic test_backpressure();
		int held;
		long_hold = 1'b1;
		fork
			begin
				held = 0;
				while (held < 3000) begin
					@(posedge clk);
					held++;
				end
				long_hold = 1'b0;
			end
			test_random(6);
		join
		drain();
	endtask

	initial begin
		reset_table();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		write_base('1);
		test_random(10);
		drain();
		write_base(32'h8000_0000);
		test_random(10);
		drain();
		test_wrapping_base();
		test_backpressure();
		write_base($urandom);
		stall_random = 1'b0;
		test_random(10);
		stall_random = 1'b1;
		drain();
		write_base('0);
		test_fill_table();
		test_random(10);
		drain();
		$display("%0d items sent, %0d results checked over several pool bases,",
			items_sent, answers_seen);
		$display("including a full table, wrapping regions and a long output hold.");
		if (mismatches == 0 && pending_answers.size() == 0) begin
			$display("** virtual_region_table_allocator: PASSED **");
		end else begin
			$display("** virtual_region_table_allocator: FAILED **");
		end
		$finish;
	end
endmodule

// File: sim.f
+incdir+rtl
rtl/vrta_pkg.sv
rtl/vrta_cell.sv
rtl/vrta_ctrl.sv
rtl/virtual_region_table_allocator.sv
tb/tb_top.sv
